>>> sv/hrtp_pkg.sv
package hrtp_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;
    localparam logic [7:0]  FU_NRI_MASK      = 8'hE0;
    localparam logic [7:0]  FU_TYPE_MASK     = 8'h1F;
    localparam logic [7:0]  FU_A_TYPE        = 8'd28;
    localparam logic [13:0] MIN_PAYLOAD      = 14'd3;
    localparam logic [13:0] FU_BYTES         = 14'd2;

    typedef enum logic [1:0] {
        REG_PAYLOAD_TYPE = 2'd0,
        REG_SYNC_SOURCE  = 2'd1,
        REG_INIT_SEQ     = 2'd2,
        REG_MAX_PAYLOAD  = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        STEP_HDR_VER  = 4'd0,
        STEP_HDR_PT   = 4'd1,
        STEP_SEQ_HI   = 4'd2,
        STEP_SEQ_LO   = 4'd3,
        STEP_TS_3     = 4'd4,
        STEP_TS_2     = 4'd5,
        STEP_TS_1     = 4'd6,
        STEP_TS_0     = 4'd7,
        STEP_SSRC_3   = 4'd8,
        STEP_SSRC_2   = 4'd9,
        STEP_SSRC_1   = 4'd10,
        STEP_SSRC_0   = 4'd11,
        STEP_FU_IND   = 4'd12,
        STEP_FU_HDR   = 4'd13,
        STEP_DATA     = 4'd14
    } step_t;

    typedef struct packed {
        logic        has_header;
        logic        marker;
        logic        has_fu;
        logic        fu_start;
        logic        fu_end;
        logic        has_data;
        logic        last;
        logic [7:0]  unit_header;
        logic [15:0] seq_num;
        logic [31:0] stamp;
        logic [7:0]  data;
    } hrtp_cmd_t;

    typedef struct packed {
        logic [6:0]  payload_type;
        logic [31:0] sync_source;
    } hrtp_hdr_cfg_t;

endpackage

>>> sv/hrtp_front.sv
module hrtp_front #(
    parameter int LENGTH_BITS = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [7:0]        data_byte,
    input  logic              unit_start,
    input  logic [23:0]       unit_length,
    input  logic [31:0]       time_stamp,
    input  logic              frame_end,
    input  logic [13:0]       max_payload,
    input  logic              seq_load,
    input  logic [15:0]       seq_value,
    output logic              cmd_push,
    output hrtp_pkg::hrtp_cmd_t cmd
);
    import hrtp_pkg::*;

    localparam logic [23:0] LEN_MASK = 24'((64'd1 << LENGTH_BITS) - 64'd1);

    logic [15:0] seq_reg, seq_next;
    logic [23:0] bytes_left_reg, bytes_left_next;
    logic [13:0] pcount_reg, pcount_next;
    logic [7:0]  uheader_reg, uheader_next;
    logic        frag_reg, frag_next;
    logic [31:0] stamp_reg, stamp_next;
    logic        fend_reg, fend_next;

    logic [23:0] len;
    logic [13:0] lim;
    logic [13:0] lim_m2;
    logic        fits;
    logic        new_frag;
    logic        frag_end;
    logic [23:0] bl_dec;
    logic [13:0] pc_base;
    logic [13:0] pc_inc;
    logic        cont_last;

    assign len      = unit_length & LEN_MASK;
    assign lim      = (max_payload < MIN_PAYLOAD) ? MIN_PAYLOAD : max_payload;
    assign lim_m2   = lim - FU_BYTES;
    assign fits     = len <= {10'd0, lim};
    assign new_frag = frag_reg && (pcount_reg == 14'd0);
    assign frag_end = bytes_left_reg <= {10'd0, lim_m2};
    assign bl_dec   = bytes_left_reg - 24'd1;
    assign pc_base  = new_frag ? FU_BYTES : pcount_reg;
    assign pc_inc   = pc_base + 14'd1;
    assign cont_last = (bl_dec == 24'd0) || (frag_reg && (pc_inc >= lim));

    always_comb begin
        seq_next        = seq_reg;
        bytes_left_next = bytes_left_reg;
        pcount_next     = pcount_reg;
        uheader_next    = uheader_reg;
        frag_next       = frag_reg;
        stamp_next      = stamp_reg;
        fend_next       = fend_reg;
        cmd_push        = 1'b0;
        cmd             = '0;
        cmd.seq_num     = seq_reg;
        cmd.stamp       = stamp_reg;
        cmd.unit_header = uheader_reg;
        cmd.data        = data_byte;
        if (in_valid) begin
            if (unit_start) begin
                bytes_left_next = '0;
                pcount_next     = '0;
                frag_next       = 1'b0;
                if (len != 24'd0) begin
                    stamp_next      = time_stamp;
                    fend_next       = frame_end;
                    uheader_next    = data_byte;
                    bytes_left_next = len - 24'd1;
                    seq_next        = seq_reg + 16'd1;
                    cmd_push        = 1'b1;
                    cmd.has_header  = 1'b1;
                    cmd.stamp       = time_stamp;
                    cmd.unit_header = data_byte;
                    if (fits) begin
                        cmd.marker   = frame_end;
                        cmd.has_data = 1'b1;
                        cmd.last     = (len == 24'd1);
                        pcount_next  = 14'd1;
                    end else begin
                        frag_next    = 1'b1;
                        cmd.has_fu   = 1'b1;
                        cmd.fu_start = 1'b1;
                        pcount_next  = FU_BYTES;
                    end
                end
            end else if (bytes_left_reg != 24'd0) begin
                cmd_push        = 1'b1;
                cmd.has_header  = new_frag;
                cmd.marker      = frag_end && fend_reg;
                cmd.has_fu      = new_frag;
                cmd.fu_end      = frag_end;
                cmd.has_data    = 1'b1;
                cmd.last        = cont_last;
                bytes_left_next = bl_dec;
                pcount_next     = cont_last ? 14'd0 : pc_inc;
                if (new_frag) begin
                    seq_next = seq_reg + 16'd1;
                end
            end
        end
        if (seq_load) begin
            seq_next = seq_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg        <= '0;
            bytes_left_reg <= '0;
            pcount_reg     <= '0;
            uheader_reg    <= '0;
            frag_reg       <= 1'b0;
            stamp_reg      <= '0;
            fend_reg       <= 1'b0;
        end else begin
            seq_reg        <= seq_next;
            bytes_left_reg <= bytes_left_next;
            pcount_reg     <= pcount_next;
            uheader_reg    <= uheader_next;
            frag_reg       <= frag_next;
            stamp_reg      <= stamp_next;
            fend_reg       <= fend_next;
        end
    end

endmodule

>>> sv/hrtp_queue.sv
module hrtp_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  hrtp_pkg::hrtp_cmd_t din,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output hrtp_pkg::hrtp_cmd_t dout
);
    import hrtp_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    hrtp_cmd_t             entries_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg;

    assign full      = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign dout      = entries_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_BITS'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_BITS'(1);
            end
        end
    end

endmodule

>>> sv/hrtp_back.sv
module hrtp_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   head_valid,
    input  hrtp_pkg::hrtp_cmd_t    head,
    input  hrtp_pkg::hrtp_hdr_cfg_t hdr_cfg,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);
    import hrtp_pkg::*;

    step_t      step_reg;
    logic       active_reg;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tuser_reg;
    logic       m_tlast_reg;

    step_t      first_step;
    step_t      cur_step;
    step_t      step_next;
    logic       done;
    logic       load;
    logic       emit;
    logic [7:0] byte_out;

    assign first_step = head.has_header ? STEP_HDR_VER :
                        (head.has_fu ? STEP_FU_IND : STEP_DATA);
    assign cur_step   = active_reg ? step_reg : first_step;
    assign load       = !m_tvalid_reg || m_tready;
    assign emit       = head_valid && load;
    assign pop        = emit && done;

    always_comb begin
        case (cur_step)
            STEP_HDR_VER: byte_out = RTP_VERSION_BYTE;
            STEP_HDR_PT:  byte_out = {head.marker, hdr_cfg.payload_type};
            STEP_SEQ_HI:  byte_out = head.seq_num[15:8];
            STEP_SEQ_LO:  byte_out = head.seq_num[7:0];
            STEP_TS_3:    byte_out = head.stamp[31:24];
            STEP_TS_2:    byte_out = head.stamp[23:16];
            STEP_TS_1:    byte_out = head.stamp[15:8];
            STEP_TS_0:    byte_out = head.stamp[7:0];
            STEP_SSRC_3:  byte_out = hdr_cfg.sync_source[31:24];
            STEP_SSRC_2:  byte_out = hdr_cfg.sync_source[23:16];
            STEP_SSRC_1:  byte_out = hdr_cfg.sync_source[15:8];
            STEP_SSRC_0:  byte_out = hdr_cfg.sync_source[7:0];
            STEP_FU_IND:  byte_out = (head.unit_header & FU_NRI_MASK) | FU_A_TYPE;
            STEP_FU_HDR:  byte_out = (head.unit_header & FU_TYPE_MASK)
                                     | {head.fu_start, head.fu_end, 6'd0};
            STEP_DATA:    byte_out = head.data;
            default:      byte_out = '0;
        endcase
    end

    always_comb begin
        done      = 1'b0;
        step_next = step_t'(4'(cur_step) + 4'd1);
        case (cur_step)
            STEP_SSRC_0: begin
                step_next = head.has_fu ? STEP_FU_IND : STEP_DATA;
                done      = !head.has_fu && !head.has_data;
            end
            STEP_FU_HDR: begin
                step_next = STEP_DATA;
                done      = !head.has_data;
            end
            STEP_DATA: begin
                step_next = STEP_HDR_VER;
                done      = 1'b1;
            end
            default: begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            step_reg     <= STEP_HDR_VER;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_tvalid_reg <= head_valid;
            end
            if (emit) begin
                active_reg <= !done;
                step_reg   <= step_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= byte_out;
            m_tuser_reg <= (cur_step == STEP_HDR_VER);
            m_tlast_reg <= done && head.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> sv/h264_rtp_packetizer_core.sv
// H.264 to RTP packetizer (single NAL unit packets and FU-A fragments).
// Input channel (s_): one NAL unit byte per item. s_tuser marks the first
// byte of a unit; with it, s_tdata also carries the unit length and the RTP
// timestamp, and s_tlast says the unit ends an access unit (sets the marker).
// Output channel (m_): one RTP packet byte per item, header first. m_tuser
// marks the first header byte of a packet and m_tlast its final byte.
// The APB port holds payload type, SSRC, initial sequence and payload limit;
// writing the initial sequence also loads the sequence counter. Registers are
// to be written by the user only while the block is idle; nothing checks it.
// An accepted byte passes through a queue entry and the output register before
// it reaches m_tdata. Each accepted byte yields one output byte, plus 12 bytes
// for an RTP header when it opens a packet and 2 FU bytes when that packet is
// a fragment; the first byte of a fragmented unit is carried only in the FU
// bytes, so it yields 14. The back end emits all bytes on one output byte path.
// A four-entry queue lets the input run up to four bytes ahead while a header
// goes out; s_tready falls once the queue is full. Reset empties the queue,
// clears the output valid and all unit state and restores register defaults.
// When the receiver stalls, the output byte holds, the queue fills and
// s_tready falls.
module h264_rtp_packetizer_core #(
    parameter int LENGTH_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // data_byte[7:0], unit_length[31:8], time_stamp[63:32]
    input  logic        s_tuser,   // unit_start
    input  logic        s_tlast,   // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tuser,   // packet_first
    output logic        m_tlast,   // packet_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hrtp_pkg::*;

    logic [6:0]  payload_type_reg;
    logic [31:0] sync_source_reg;
    logic [15:0] init_seq_reg;
    logic [13:0] max_payload_reg;

    reg_index_t    reg_sel;
    logic          cfg_write;
    logic          seq_load;
    logic          in_valid;
    logic          cmd_push;
    hrtp_cmd_t     cmd;
    logic          q_full;
    logic          q_not_empty;
    logic          q_pop;
    hrtp_cmd_t     q_head;
    hrtp_hdr_cfg_t hdr_cfg;

    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign seq_load  = cfg_write && (reg_sel == REG_INIT_SEQ);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            payload_type_reg <= 7'd96;
            sync_source_reg  <= '0;
            init_seq_reg     <= '0;
            max_payload_reg  <= 14'd1400;
        end else if (cfg_write) begin
            case (reg_sel)
                REG_PAYLOAD_TYPE: payload_type_reg <= pwdata[6:0];
                REG_SYNC_SOURCE:  sync_source_reg  <= pwdata;
                REG_INIT_SEQ:     init_seq_reg     <= pwdata[15:0];
                REG_MAX_PAYLOAD:  max_payload_reg  <= pwdata[13:0];
                default:          payload_type_reg <= payload_type_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_PAYLOAD_TYPE: prdata = {25'd0, payload_type_reg};
            REG_SYNC_SOURCE:  prdata = sync_source_reg;
            REG_INIT_SEQ:     prdata = {16'd0, init_seq_reg};
            REG_MAX_PAYLOAD:  prdata = {18'd0, max_payload_reg};
            default:          prdata = '0;
        endcase
    end

    assign s_tready = !q_full;
    assign in_valid = s_tvalid && s_tready;

    assign hdr_cfg.payload_type = payload_type_reg;
    assign hdr_cfg.sync_source  = sync_source_reg;

    hrtp_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (in_valid),
        .data_byte   (s_tdata[7:0]),
        .unit_start  (s_tuser),
        .unit_length (s_tdata[31:8]),
        .time_stamp  (s_tdata[63:32]),
        .frame_end   (s_tlast),
        .max_payload (max_payload_reg),
        .seq_load    (seq_load),
        .seq_value   (pwdata[15:0]),
        .cmd_push    (cmd_push),
        .cmd         (cmd)
    );

    hrtp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .din       (cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .dout      (q_head)
    );

    hrtp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_not_empty),
        .head       (q_head),
        .hdr_cfg    (hdr_cfg),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

>>> sv/hrtp_checker.sv
module hrtp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);
    import hrtp_pkg::*;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("Output valid after reset.");

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("Output valid dropped while stalled.");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("Output item changed while stalled.");

    a_first_is_version: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == RTP_VERSION_BYTE))
        else $error("Packet does not start with the version byte.");

    a_first_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser && m_tlast))
        else $error("A packet byte is both first and last.");

endmodule

bind h264_rtp_packetizer_core hrtp_checker u_hrtp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
